@@ design/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants of the cubic Bezier easing evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Width of every input and output field
  localparam int FIELD_W = 17;

  // Default configuration of the datapath
  localparam int NEWTON_STEPS_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // One curve request: control points and progress, unsigned fixed point
  typedef struct packed {
    logic [FIELD_W-1:0] x1;
    logic [FIELD_W-1:0] y1;
    logic [FIELD_W-1:0] x2;
    logic [FIELD_W-1:0] y2;
    logic [FIELD_W-1:0] prog;
  } cbe_item_t;

endpackage

@@ design/cbe_fxmul.sv @@
// ----------------------------------------------------------------------------
// cbe_fxmul
// Signed fixed-point product: magnitude rounded half away from zero, then
// the sign of the operands applied.
// ----------------------------------------------------------------------------
module cbe_fxmul #(
  parameter int AW        = 21,
  parameter int BW        = 21,
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
  input  logic signed [AW-1:0]              a_i,
  input  logic signed [BW-1:0]              b_i,
  output logic signed [AW+BW-FRAC_BITS-1:0] r_o
);
  localparam int PW = AW + BW;
  localparam int RW = PW - FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [AW-1:0] mag_a;
  logic [BW-1:0] mag_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [RW-1:0] mag_r;
  logic          neg;

  // Multiply magnitudes, round, restore sign
  always_comb begin
    mag_a    = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
    mag_b    = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
    neg      = a_i[AW-1] ^ b_i[BW-1];
    prod     = PW'(mag_a) * PW'(mag_b);
    prod_rnd = (prod + HALF) >> FRAC_BITS;
    mag_r    = prod_rnd[RW-1:0];
    r_o      = neg ? -$signed(mag_r) : $signed(mag_r);
  end

endmodule

@@ design/cbe_divider.sv @@
// ----------------------------------------------------------------------------
// cbe_divider
// Pipelined restoring divider, two quotient bits per stage, with a side
// vector that travels alongside. Flags quotients that need more than QB bits.
// ----------------------------------------------------------------------------
module cbe_divider #(
  parameter int DW  = 36,
  parameter int QB  = 22,
  parameter int SBW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW+QB-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SBW-1:0]   side_i,
  output logic             valid_o,
  output logic [QB-1:0]    quot_o,
  output logic             ovf_o,
  output logic [SBW-1:0]   side_o
);
  localparam int CW = DW + QB;
  localparam int NS = (QB + 1) / 2;

  logic           v_q    [NS];
  logic [CW-1:0]  rem_q  [NS];
  logic [QB-1:0]  quo_q  [NS];
  logic [DW-1:0]  den_q  [NS];
  logic           ovf_q  [NS];
  logic [SBW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int HI = QB - 1 - 2 * k;

    logic           v_in;
    logic [CW-1:0]  rem_in;
    logic [QB-1:0]  quo_in;
    logic [DW-1:0]  den_in;
    logic           ovf_in;
    logic [SBW-1:0] side_in;
    logic [CW-1:0]  rem_mid;
    logic [QB-1:0]  quo_mid;
    logic [CW-1:0]  rem_d;
    logic [QB-1:0]  quo_d;

    // Stage input: first stage also checks for quotient overflow
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign ovf_in  = (num_i >= (CW'(den_i) << QB));
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Upper bit of this stage
    always_comb begin
      rem_mid = rem_in;
      quo_mid = quo_in;
      if (rem_in >= (CW'(den_in) << HI)) begin
        rem_mid     = rem_in - (CW'(den_in) << HI);
        quo_mid[HI] = 1'b1;
      end
    end

    // Lower bit, where one is left
    if (HI >= 1) begin : g_lo
      always_comb begin
        rem_d = rem_mid;
        quo_d = quo_mid;
        if (rem_mid >= (CW'(den_in) << (HI - 1))) begin
          rem_d         = rem_mid - (CW'(den_in) << (HI - 1));
          quo_d[HI - 1] = 1'b1;
        end
      end
    end else begin : g_nolo
      assign rem_d = rem_mid;
      assign quo_d = quo_mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        ovf_q[k]  <= ovf_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

@@ design/cbe_newton_step.sv @@
// ----------------------------------------------------------------------------
// cbe_newton_step
// One Newton step on X(t) = progress: polynomial and slope over three
// product stages, residual stage, pipelined quotient, then update of t.
// ----------------------------------------------------------------------------
module cbe_newton_step #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [FRAC_BITS+4:0] t_i,
  input  cbe_pkg::cbe_item_t         item_i,
  output logic                       valid_o,
  output logic signed [FRAC_BITS+4:0] t_o,
  output cbe_pkg::cbe_item_t         item_o
);
  import cbe_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int TW  = F + 5;
  localparam int PW  = FIELD_W + 1;
  localparam int W2  = 2 * TW - F;
  localparam int W3  = W2 + TW - F;
  localparam int WK  = W2 + PW - F;
  localparam int WP  = W3 + PW - F;
  localparam int MW  = (F > FIELD_W) ? F : FIELD_W;
  localparam int VW  = MW + 20;
  localparam int DW  = VW - 1;
  localparam int QB  = F + 6;
  localparam int CW  = DW + QB;
  localparam int UW  = QB + 2;
  localparam int SBW = TW + 2 + $bits(cbe_item_t);

  localparam logic signed [TW-1:0] ONE_T  = TW'(1) <<< F;
  localparam logic [QB-1:0]        QMAX   = QB'(1) << (F + 5);
  localparam logic signed [UW-1:0] TLIM_U = UW'(1) <<< (F + 3);

  // Stage A: s = 1 - t and the square terms
  logic signed [TW-1:0] s_a;
  logic signed [W2-1:0] s2_a, t2_a, st_a;

  assign s_a = ONE_T - t_i;

  cbe_fxmul #(.AW(TW), .BW(TW), .FRAC_BITS(F)) u_ss (.a_i(s_a), .b_i(s_a), .r_o(s2_a));
  cbe_fxmul #(.AW(TW), .BW(TW), .FRAC_BITS(F)) u_tt (.a_i(t_i), .b_i(t_i), .r_o(t2_a));
  cbe_fxmul #(.AW(TW), .BW(TW), .FRAC_BITS(F)) u_st (.a_i(s_a), .b_i(t_i), .r_o(st_a));

  logic                 va_q;
  logic signed [TW-1:0] ta_q, sa_q;
  logic signed [W2-1:0] s2a_q, t2a_q, sta_q;
  cbe_item_t            ia_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q  <= t_i;
      sa_q  <= s_a;
      s2a_q <= s2_a;
      t2a_q <= t2_a;
      sta_q <= st_a;
      ia_q  <= item_i;
    end
  end

  // Stage B: cubic basis terms and slope products
  logic signed [PW-1:0] x1_a, x2_a;
  logic signed [W3-1:0] a_b, b_b, c_b;
  logic signed [WK-1:0] k1_b, k2_b, k3_b, k4_b;

  assign x1_a = $signed({1'b0, ia_q.x1});
  assign x2_a = $signed({1'b0, ia_q.x2});

  cbe_fxmul #(.AW(W2), .BW(TW), .FRAC_BITS(F)) u_a (.a_i(s2a_q), .b_i(ta_q), .r_o(a_b));
  cbe_fxmul #(.AW(TW), .BW(W2), .FRAC_BITS(F)) u_b (.a_i(sa_q), .b_i(t2a_q), .r_o(b_b));
  cbe_fxmul #(.AW(W2), .BW(TW), .FRAC_BITS(F)) u_c (.a_i(t2a_q), .b_i(ta_q), .r_o(c_b));
  cbe_fxmul #(.AW(W2), .BW(PW), .FRAC_BITS(F)) u_k1 (.a_i(s2a_q), .b_i(x1_a), .r_o(k1_b));
  cbe_fxmul #(.AW(W2), .BW(PW), .FRAC_BITS(F)) u_k2 (.a_i(sta_q), .b_i(x1_a), .r_o(k2_b));
  cbe_fxmul #(.AW(W2), .BW(PW), .FRAC_BITS(F)) u_k3 (.a_i(sta_q), .b_i(x2_a), .r_o(k3_b));
  cbe_fxmul #(.AW(W2), .BW(PW), .FRAC_BITS(F)) u_k4 (.a_i(t2a_q), .b_i(x2_a), .r_o(k4_b));

  logic                 vb_q;
  logic signed [TW-1:0] tb_q;
  logic signed [W3-1:0] ab_q, bb_q, cb_q;
  logic signed [WK-1:0] k1b_q, k2b_q, k3b_q, k4b_q;
  logic signed [W2-1:0] t2b_q;
  cbe_item_t            ib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tb_q  <= ta_q;
      ab_q  <= a_b;
      bb_q  <= b_b;
      cb_q  <= c_b;
      k1b_q <= k1_b;
      k2b_q <= k2_b;
      k3b_q <= k3_b;
      k4b_q <= k4_b;
      t2b_q <= t2a_q;
      ib_q  <= ia_q;
    end
  end

  // Stage C: weighted control products and the derivative
  logic signed [PW-1:0] x1_b, x2_b;
  logic signed [WP-1:0] pa_c, pb_c;
  logic signed [VW-1:0] e1, e2, e3, e4, e5, d_c;

  assign x1_b = $signed({1'b0, ib_q.x1});
  assign x2_b = $signed({1'b0, ib_q.x2});

  cbe_fxmul #(.AW(W3), .BW(PW), .FRAC_BITS(F)) u_pa (.a_i(ab_q), .b_i(x1_b), .r_o(pa_c));
  cbe_fxmul #(.AW(W3), .BW(PW), .FRAC_BITS(F)) u_pb (.a_i(bb_q), .b_i(x2_b), .r_o(pb_c));

  // X'(t) = 3 s2 x1 - 6 st x1 + 6 st x2 - 3 t2 x2 + 3 t2
  always_comb begin
    e1  = VW'(k1b_q);
    e2  = VW'(k2b_q);
    e3  = VW'(k3b_q);
    e4  = VW'(k4b_q);
    e5  = VW'(t2b_q);
    d_c = (e1 + (e1 <<< 1)) - (e2 <<< 1) - (e2 <<< 2) + (e3 <<< 1) + (e3 <<< 2)
          - (e4 + (e4 <<< 1)) + (e5 + (e5 <<< 1));
  end

  logic                 vc_q;
  logic signed [TW-1:0] tc_q;
  logic signed [WP-1:0] pac_q, pbc_q;
  logic signed [W3-1:0] cc_q;
  logic signed [VW-1:0] dc_q;
  cbe_item_t            ic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q  <= tb_q;
      pac_q <= pa_c;
      pbc_q <= pb_c;
      cc_q  <= cb_q;
      dc_q  <= d_c;
      ic_q  <= ib_q;
    end
  end

  // Stage D: residual, magnitudes and signs for the quotient.
  // |f| stays far below 2^DW, where its magnitude is cut for the quotient, for every input pattern.
  logic signed [VW-1:0] pa_e, pb_e, f_d;
  logic [VW-1:0]        fm_d, dm_d;
  logic [CW-1:0]        num_d;

  always_comb begin
    pa_e  = VW'(pac_q);
    pb_e  = VW'(pbc_q);
    f_d   = (pa_e + (pa_e <<< 1)) + (pb_e + (pb_e <<< 1)) + VW'(cc_q)
            - VW'($signed({1'b0, ic_q.prog}));
    fm_d  = f_d[VW-1] ? VW'(-f_d) : VW'(f_d);
    dm_d  = dc_q[VW-1] ? VW'(-dc_q) : VW'(dc_q);
    num_d = CW'(fm_d[DW-1:0]) << F;
  end

  logic                 vd_q;
  logic [CW-1:0]        numd_q;
  logic [DW-1:0]        dend_q;
  logic [SBW-1:0]       sided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numd_q  <= num_d;
      dend_q  <= dm_d[DW-1:0];
      sided_q <= {tc_q, f_d[VW-1] ^ dc_q[VW-1], (dc_q == '0), ic_q};
    end
  end

  // Quotient |f| * ONE / |d|
  logic                 vq;
  logic [QB-1:0]        quot;
  logic                 ovf;
  logic [SBW-1:0]       side_q;

  cbe_divider #(.DW(DW), .QB(QB), .SBW(SBW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vd_q),
    .num_i   (numd_q),
    .den_i   (dend_q),
    .side_i  (sided_q),
    .valid_o (vq),
    .quot_o  (quot),
    .ovf_o   (ovf),
    .side_o  (side_q)
  );

  // Stage E: step t, keep it on a zero slope, bound it to +-8
  logic signed [TW-1:0] t_e;
  logic                 neg_e, dz_e;
  cbe_item_t            i_e;
  logic [QB-1:0]        qs_e;
  logic signed [UW-1:0] tn_e;
  logic signed [TW-1:0] t_d;

  always_comb begin
    {t_e, neg_e, dz_e, i_e} = side_q;
    qs_e = (ovf || (quot > QMAX)) ? QMAX : quot;
    tn_e = neg_e ? (UW'(t_e) + $signed({2'b00, qs_e}))
                 : (UW'(t_e) - $signed({2'b00, qs_e}));
    if (tn_e > TLIM_U) begin
      tn_e = TLIM_U;
    end else if (tn_e < -TLIM_U) begin
      tn_e = -TLIM_U;
    end
    t_d = dz_e ? t_e : TW'(tn_e);
  end

  logic                 ve_q;
  logic signed [TW-1:0] te_q;
  cbe_item_t            ie_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      te_q <= t_d;
      ie_q <= i_e;
    end
  end

  assign valid_o = ve_q;
  assign t_o     = te_q;
  assign item_o  = ie_q;

endmodule

@@ design/cbe_curve_y.sv @@
// ----------------------------------------------------------------------------
// cbe_curve_y
// Final curve evaluation: clamp t to [0,1], form Y(t) over four stages and
// saturate the result to the output range.
// ----------------------------------------------------------------------------
module cbe_curve_y #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+4:0] t_i,
  input  cbe_pkg::cbe_item_t          item_i,
  output logic                        valid_o,
  output logic [cbe_pkg::FIELD_W-1:0] y_o
);
  import cbe_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int TW = F + 5;
  localparam int PW = FIELD_W + 1;
  localparam int W2 = 2 * TW - F;
  localparam int W3 = W2 + TW - F;
  localparam int WP = W3 + PW - F;
  localparam int MW = (F > FIELD_W) ? F : FIELD_W;
  localparam int VW = MW + 20;

  localparam logic signed [TW-1:0] ONE_T  = TW'(1) <<< F;
  localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< F;
  localparam logic signed [VW-1:0] YMAX_V = (F < FIELD_W) ? ONE_V
                                          : VW'((1 << FIELD_W) - 1);

  // Stage 0: clamp and squares
  logic signed [TW-1:0] tc_0, s_0;
  logic signed [W2-1:0] s2_0, t2_0;

  always_comb begin
    tc_0 = t_i;
    if (t_i < 0) begin
      tc_0 = '0;
    end else if (t_i > ONE_T) begin
      tc_0 = ONE_T;
    end
    s_0 = ONE_T - tc_0;
  end

  cbe_fxmul #(.AW(TW), .BW(TW), .FRAC_BITS(F)) u_ss (.a_i(s_0), .b_i(s_0), .r_o(s2_0));
  cbe_fxmul #(.AW(TW), .BW(TW), .FRAC_BITS(F)) u_tt (.a_i(tc_0), .b_i(tc_0), .r_o(t2_0));

  logic                 v0_q;
  logic signed [TW-1:0] t0_q, s0_q;
  logic signed [W2-1:0] s20_q, t20_q;
  logic [FIELD_W-1:0]   y1_0_q, y2_0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q   <= tc_0;
      s0_q   <= s_0;
      s20_q  <= s2_0;
      t20_q  <= t2_0;
      y1_0_q <= item_i.y1;
      y2_0_q <= item_i.y2;
    end
  end

  // Stage 1: cubic basis terms
  logic signed [W3-1:0] a_1, b_1, c_1;

  cbe_fxmul #(.AW(W2), .BW(TW), .FRAC_BITS(F)) u_a (.a_i(s20_q), .b_i(t0_q), .r_o(a_1));
  cbe_fxmul #(.AW(TW), .BW(W2), .FRAC_BITS(F)) u_b (.a_i(s0_q), .b_i(t20_q), .r_o(b_1));
  cbe_fxmul #(.AW(W2), .BW(TW), .FRAC_BITS(F)) u_c (.a_i(t20_q), .b_i(t0_q), .r_o(c_1));

  logic                 v1_q;
  logic signed [W3-1:0] a1_q, b1_q, c1_q;
  logic [FIELD_W-1:0]   y1_1_q, y2_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a_1;
      b1_q   <= b_1;
      c1_q   <= c_1;
      y1_1_q <= y1_0_q;
      y2_1_q <= y2_0_q;
    end
  end

  // Stage 2: weight by the control y values
  logic signed [PW-1:0] y1_s, y2_s;
  logic signed [WP-1:0] pa_2, pb_2;

  assign y1_s = $signed({1'b0, y1_1_q});
  assign y2_s = $signed({1'b0, y2_1_q});

  cbe_fxmul #(.AW(W3), .BW(PW), .FRAC_BITS(F)) u_pa (.a_i(a1_q), .b_i(y1_s), .r_o(pa_2));
  cbe_fxmul #(.AW(W3), .BW(PW), .FRAC_BITS(F)) u_pb (.a_i(b1_q), .b_i(y2_s), .r_o(pb_2));

  logic                 v2_q;
  logic signed [WP-1:0] pa2_q, pb2_q;
  logic signed [W3-1:0] c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa2_q <= pa_2;
      pb2_q <= pb_2;
      c2_q  <= c1_q;
    end
  end

  // Stage 3: sum and saturate
  logic signed [VW-1:0] pa_e, pb_e, y_3;

  always_comb begin
    pa_e = VW'(pa2_q);
    pb_e = VW'(pb2_q);
    y_3  = (pa_e + (pa_e <<< 1)) + (pb_e + (pb_e <<< 1)) + VW'(c2_q);
    if (y_3 < 0) begin
      y_3 = '0;
    end else if (y_3 > YMAX_V) begin
      y_3 = YMAX_V;
    end
  end

  logic               v3_q;
  logic [FIELD_W-1:0] y3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y3_q <= y_3[FIELD_W-1:0];
    end
  end

  assign valid_o = v3_q;
  assign y_o     = y3_q;

endmodule

@@ design/cubic_bezier_easing_eval_core.sv @@
// Each Newton step is 3 product stages, a residual stage, a 2-bit-per-stage
// divider of (FRAC_BITS + 7) / 2 stages and an update stage; 4 stages for Y.
// Throughput: one transfer per cycle; the whole pipeline holds while a valid output is stalled.
// Reset: asynchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval_core
// Easing curve evaluator: unrolled Newton solve of X(t) = progress, then Y(t).
// ----------------------------------------------------------------------------
module cubic_bezier_easing_eval_core #(
  parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
  parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cbe_pkg::FIELD_W-1:0] ctrl_x1_i,
  input  logic [cbe_pkg::FIELD_W-1:0] ctrl_y1_i,
  input  logic [cbe_pkg::FIELD_W-1:0] ctrl_x2_i,
  input  logic [cbe_pkg::FIELD_W-1:0] ctrl_y2_i,
  input  logic [cbe_pkg::FIELD_W-1:0] progress_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cbe_pkg::FIELD_W-1:0] eased_value_o
);
  import cbe_pkg::*;

  localparam int TW = FRAC_BITS + 5;
  localparam logic signed [TW-1:0] T_START = TW'(1) <<< (FRAC_BITS - 1);

  // Pipeline advances unless a finished result is held back
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic                 v_c [NEWTON_STEPS+1];
  logic signed [TW-1:0] t_c [NEWTON_STEPS+1];
  cbe_item_t            i_c [NEWTON_STEPS+1];

  assign v_c[0]      = in_valid_i;
  assign t_c[0]      = T_START;
  assign i_c[0].x1   = ctrl_x1_i;
  assign i_c[0].y1   = ctrl_y1_i;
  assign i_c[0].x2   = ctrl_x2_i;
  assign i_c[0].y2   = ctrl_y2_i;
  assign i_c[0].prog = progress_i;

  // Unrolled Newton steps
  for (genvar n = 0; n < NEWTON_STEPS; n++) begin : g_step
    cbe_newton_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[n]),
      .t_i     (t_c[n]),
      .item_i  (i_c[n]),
      .valid_o (v_c[n+1]),
      .t_o     (t_c[n+1]),
      .item_o  (i_c[n+1])
    );
  end

  // Curve y at the solved parameter
  cbe_curve_y #(.FRAC_BITS(FRAC_BITS)) u_curve_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_c[NEWTON_STEPS]),
    .t_i     (t_c[NEWTON_STEPS]),
    .item_i  (i_c[NEWTON_STEPS]),
    .valid_o (out_valid_o),
    .y_o     (eased_value_o)
  );

endmodule
